>>> hw/rtl/bytecode_instruction_encoder_defines.svh
// Assertion macros for the bytecode instruction encoder.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef BYTECODE_INSTRUCTION_ENCODER_DEFINES_SVH
`define BYTECODE_INSTRUCTION_ENCODER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BIE_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define BIE_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define BIE_ASSERT(label, clk, rstn, prop, msg)
`define BIE_ASSERT_IMPL(label, clk, rstn, ante, cons, msg)
`endif
`endif

>>> hw/rtl/bie_pkg.sv
// Shared widths, action codes and stage payload types of the bytecode encoder.
// No dependencies; imported by every module of the block.
package bie_pkg;

    localparam int BYTE_W    = 8;
    localparam int ACTION_W  = 2;
    localparam int OPCODE_W  = 16;
    localparam int OPERAND_W = 64;
    localparam int FCODE_W   = 8;
    localparam int TDATA_W   = 88;   // opcode + operand + function code, whole bytes

    localparam int GRP_W     = 7;    // payload bits per varint byte
    localparam int OPC_MAX   = 3;    // opcode bytes, worst case
    localparam int VLQ_MAX   = 10;   // operand bytes, worst case
    localparam int MAX_BYTES = 13;   // bytes per instruction, worst case
    localparam int LEN_W     = 4;
    localparam int OLEN_W    = 2;

    localparam logic [ACTION_W-1:0] ACT_OPCODE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_VARINT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RAW    = 2'd2;

    localparam logic [OPCODE_W-1:0] OPC_ONE_LIMIT = 16'h007F;
    localparam logic [OPCODE_W-1:0] OPC_TWO_LIMIT = 16'h3FFF;

    typedef logic [BYTE_W-1:0] byte_t;

    // Bytes are stored with the last emitted byte at index 0.
    typedef struct packed {
        logic [OLEN_W-1:0]         opc_len;
        byte_t [OPC_MAX-1:0]       opc_bytes;
        logic [LEN_W-1:0]          tail_len;
        byte_t [VLQ_MAX-1:0]       tail_bytes;
    } dec_t;

    // Whole instruction; first emitted byte sits at index total-1.
    typedef struct packed {
        logic [LEN_W-1:0]          total;
        byte_t [MAX_BYTES-1:0]     bytes;
    } frame_t;

endpackage

>>> hw/rtl/bie_decode.sv
// Stage 1: splits opcode and operand into 7-bit groups and sizes both parts.
// Depends on bie_pkg and the assertion macros header.
`include "bytecode_instruction_encoder_defines.svh"

module bie_decode
    import bie_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [ACTION_W-1:0]  action,
    input  logic [OPCODE_W-1:0]  opcode,
    input  logic [OPERAND_W-1:0] operand,
    input  logic [FCODE_W-1:0]   fcode,
    output logic                 out_valid,
    input  logic                 out_ready,
    output dec_t                 out_dec
);

    logic                 valid_reg;
    logic                 valid_next;
    dec_t                 dec_reg;
    dec_t                 dec_next;
    logic [GRP_W-1:0]     grp [VLQ_MAX];
    logic [LEN_W-1:0]     vlq_len;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_dec   = dec_reg;

    always_comb begin
        for (int i = 0; i < VLQ_MAX - 1; i++) begin
            grp[i] = operand[GRP_W*i +: GRP_W];
        end
        grp[VLQ_MAX-1] = GRP_W'(operand[OPERAND_W-1:GRP_W*(VLQ_MAX-1)]);
    end

    // highest nonzero group sets the length, zero still takes one byte
    always_comb begin
        vlq_len = LEN_W'(1);
        for (int i = 1; i < VLQ_MAX; i++) begin
            if (grp[i] != '0) begin
                vlq_len = LEN_W'(i + 1);
            end
        end
    end

    always_comb begin
        dec_next = dec_reg;
        if (opcode < OPC_ONE_LIMIT) begin
            dec_next.opc_len = OLEN_W'(1);
        end else if (opcode < OPC_TWO_LIMIT) begin
            dec_next.opc_len = OLEN_W'(2);
        end else begin
            dec_next.opc_len = OLEN_W'(3);
        end
        dec_next.opc_bytes[0] = {1'b0, opcode[GRP_W-1:0]};
        dec_next.opc_bytes[1] = {1'b1, opcode[2*GRP_W-1:GRP_W]};
        dec_next.opc_bytes[2] = {1'b1, (BYTE_W-1)'(opcode[OPCODE_W-1:2*GRP_W])};

        for (int i = 0; i < VLQ_MAX; i++) begin
            dec_next.tail_bytes[i] = {(i != 0), grp[i]};
        end
        case (action)
            ACT_VARINT: begin
                dec_next.tail_len = vlq_len;
            end
            ACT_RAW: begin
                dec_next.tail_len      = LEN_W'(1);
                dec_next.tail_bytes[0] = fcode;
            end
            ACT_OPCODE: begin
                dec_next.tail_len = '0;
            end
            default: begin
                dec_next.tail_len = '0;
            end
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            dec_reg <= dec_next;
        end
    end

    `BIE_ASSERT_IMPL(a_dec_len, aclk, aresetn, valid_reg, (dec_reg.opc_len != '0) && (dec_reg.tail_len <= LEN_W'(VLQ_MAX)), "decode lengths out of range")

endmodule

>>> hw/rtl/bie_pack.sv
// Stage 2: lays opcode bytes above the tail bytes into one instruction frame.
// Depends on bie_pkg and the assertion macros header.
`include "bytecode_instruction_encoder_defines.svh"

module bie_pack
    import bie_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  dec_t   in_dec,
    output logic   out_valid,
    input  logic   out_ready,
    output frame_t out_frame
);

    logic   valid_reg;
    logic   valid_next;
    frame_t frame_reg;
    frame_t frame_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_frame = frame_reg;

    // tail bytes take the low slots, opcode bytes go right above them
    always_comb begin
        logic [LEN_W:0] diff;
        frame_next.total = in_dec.tail_len + LEN_W'(in_dec.opc_len);
        for (int p = 0; p < MAX_BYTES; p++) begin
            diff = (LEN_W+1)'(p) - {1'b0, in_dec.tail_len};
            if ((p < VLQ_MAX) && (LEN_W'(p) < in_dec.tail_len)) begin
                frame_next.bytes[p] = in_dec.tail_bytes[p % VLQ_MAX];
            end else if (diff < (LEN_W+1)'(OPC_MAX)) begin
                frame_next.bytes[p] = in_dec.opc_bytes[diff[OLEN_W-1:0]];
            end else begin
                frame_next.bytes[p] = '0;
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            frame_reg <= frame_next;
        end
    end

    `BIE_ASSERT_IMPL(a_total_range, aclk, aresetn, valid_reg, (frame_reg.total != '0) && (frame_reg.total <= LEN_W'(MAX_BYTES)), "frame length out of range")

endmodule

>>> hw/rtl/bie_serial.sv
// Stages 3 and 4: holds one frame and shifts it out a byte per cycle into a
// registered output while m_ready allows. Depends on bie_pkg and the assertion macros header.
`include "bytecode_instruction_encoder_defines.svh"

module bie_serial
    import bie_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  frame_t in_frame,
    output logic   m_valid,
    input  logic   m_ready,
    output byte_t  m_byte,
    output logic   m_last
);

    logic                  hold_valid_reg;
    logic                  hold_valid_next;
    logic [LEN_W-1:0]      hold_ptr_reg;
    logic [LEN_W-1:0]      hold_ptr_next;
    byte_t [MAX_BYTES-1:0] hold_bytes_reg;
    byte_t [MAX_BYTES-1:0] hold_bytes_next;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    byte_t                 m_byte_reg;
    byte_t                 m_byte_next;
    logic                  m_last_reg;
    logic                  m_last_next;
    logic                  out_load;
    logic                  hold_done;

    assign out_load  = !m_valid_reg || m_ready;
    assign hold_done = hold_valid_reg && (hold_ptr_reg == '0) && out_load;
    assign in_ready  = !hold_valid_reg || hold_done;

    assign m_valid = m_valid_reg;
    assign m_byte  = m_byte_reg;
    assign m_last  = m_last_reg;

    always_comb begin
        m_valid_next    = m_valid_reg;
        m_byte_next     = m_byte_reg;
        m_last_next     = m_last_reg;
        hold_valid_next = hold_valid_reg;
        hold_ptr_next   = hold_ptr_reg;
        hold_bytes_next = hold_bytes_reg;
        if (out_load) begin
            m_valid_next = hold_valid_reg;
            m_byte_next  = hold_bytes_reg[hold_ptr_reg];
            m_last_next  = (hold_ptr_reg == '0);
            if (hold_valid_reg && (hold_ptr_reg != '0)) begin
                hold_ptr_next = hold_ptr_reg - LEN_W'(1);
            end
        end
        if (hold_done) begin
            hold_valid_next = 1'b0;
        end
        // next frame loads the same cycle its predecessor sends its last byte
        if (in_valid && in_ready) begin
            hold_valid_next = 1'b1;
            hold_ptr_next   = in_frame.total - LEN_W'(1);
            hold_bytes_next = in_frame.bytes;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_ptr_reg   <= hold_ptr_next;
        hold_bytes_reg <= hold_bytes_next;
        m_byte_reg     <= m_byte_next;
        m_last_reg     <= m_last_next;
    end

    `BIE_ASSERT(a_ptr_countdown, aclk, aresetn, hold_valid_reg && out_load && (hold_ptr_reg != '0) |=> hold_valid_reg && (hold_ptr_reg == $past(hold_ptr_reg) - LEN_W'(1)), "byte pointer skipped")
    `BIE_ASSERT(a_last_follows, aclk, aresetn, hold_done |=> m_valid_reg && m_last_reg, "final byte not flagged last")
    `BIE_ASSERT(a_hold_stall, aclk, aresetn, hold_valid_reg && !out_load |=> hold_valid_reg && $stable(hold_ptr_reg), "frame moved while output stalled")

endmodule

>>> hw/rtl/bytecode_instruction_encoder.sv
// Top level of the bytecode instruction encoder: stream ports and stage wiring.
// Depends on bie_pkg, bie_decode, bie_pack and bie_serial.

// Turns one instruction per input transfer into its bytecode, one byte per
// output transfer, with m_tlast on the final byte. The opcode takes 1 byte
// below 127, 2 bytes below 16383 and 3 bytes otherwise, all but its last byte
// with bit 7 set. Action 1 appends the 64-bit operand as a big-endian 7-bit
// varint (1 to 10 bytes, bit 7 set on all but the last), action 2 appends the
// raw function code byte, and actions 0 and 3 send the opcode alone. An
// instruction is sent as 1 to 13 bytes through the single byte-wide output
// register; with m_tready held high the bytes of consecutive instructions
// follow without gaps. From the input transfer to the first output byte the
// data passes the decode register, frame register, hold buffer and output
// register, in that order. Input transfers are taken while earlier
// instructions are still draining, until the pipeline registers are full.
// The block keeps no state between instructions.
module bytecode_instruction_encoder
    import bie_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_tvalid,
    output logic                s_tready,
    // [15:0] opcode, [79:16] operand, [87:80] function_code
    input  logic [TDATA_W-1:0]  s_tdata,
    // [1:0] action
    input  logic [ACTION_W-1:0] s_tuser,

    output logic                m_tvalid,
    input  logic                m_tready,
    // [7:0] out_byte
    output logic [BYTE_W-1:0]   m_tdata,
    output logic                m_tlast
);

    // decode -> pack
    logic   dec_valid;
    logic   dec_ready;
    dec_t   dec;

    // pack -> serializer
    logic   frm_valid;
    logic   frm_ready;
    frame_t frm;

    // Stage 1: group split, opcode sizing, varint length search.
    bie_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .action    (s_tuser),
        .opcode    (s_tdata[OPCODE_W-1:0]),
        .operand   (s_tdata[OPCODE_W +: OPERAND_W]),
        .fcode     (s_tdata[OPCODE_W+OPERAND_W +: FCODE_W]),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .out_dec   (dec)
    );

    // Stage 2: opcode and tail bytes merged into one frame of up to 13 bytes.
    bie_pack u_pack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_dec    (dec),
        .out_valid (frm_valid),
        .out_ready (frm_ready),
        .out_frame (frm)
    );

    // Stages 3 and 4: frame hold buffer and byte output register.
    bie_serial u_serial (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (frm_valid),
        .in_ready (frm_ready),
        .in_frame (frm),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_byte   (m_tdata),
        .m_last   (m_tlast)
    );

endmodule
